FILE: rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types, sizes and index helpers for the double-ended queue.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned DATA_WIDTH  = 32;
  localparam int unsigned IDX_W       = $clog2(DEPTH);
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1);

  // stream packing
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_DATA_W  = 32;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - OUT_DATA_W - COUNT_W;
  localparam int unsigned OUT_TUSER_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 2'd0,
    CMD_PUSH_FRONT = 2'd1,
    CMD_POP_BACK   = 2'd2,
    CMD_POP_FRONT  = 2'd3
  } cmd_e;

  // one access to the ring store
  typedef struct packed {
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic                  re;
    logic [IDX_W-1:0]      raddr;
  } ring_req_t;

  // slot index plus offset, wrapped into the ring (offset < DEPTH)
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IDX_W+1)'(DEPTH)) begin
      sum = sum - (IDX_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  // slot just before base, wrapping at zero
  function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] base);
    logic [IDX_W-1:0] res;
    if (base == '0) begin
      res = IDX_W'(DEPTH - 1);
    end else begin
      res = base - IDX_W'(1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/deq_ring.sv
// ----------------------------------------------------------------------------
// deq_ring
// Ring store of the queue: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ring
  import deq_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire ring_req_t             req_i,
  output logic      [DATA_WIDTH-1:0] rd_data_o
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // hold the last read word while the result waits downstream
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_data_q <= mem[req_i.raddr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

FILE: rtl/double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Bounded double-ended queue of words held in a ring store.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                                 tuser
//  s_axis    in   [31:0] data_in                        [1:0] cmd
//  m_axis    out  [31:0] data_out, [36:32] count_out    [0] null_result,
//                 [39:37] zero                          [1] overflow
//
//  One request per cycle unless the output stalls; each result appears in
//  the cycle after its request, set by the registered read of the ring store.
//  The front index and count update at accept, so back-to-back requests
//  never wait on the store.
//  Reset empties the queue; the store itself is not cleared.
//  A stalled result holds in the output register; input stalls only while
//  that register is full and not being taken.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_top
  import deq_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,  // [31:0] data_in
  input  wire logic [CMD_W-1:0]       s_axis_tuser_i,  // [1:0] cmd
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o,  // [31:0] data_out, [36:32] count_out
  output logic [OUT_TUSER_W-1:0]      m_axis_tuser_o   // [0] null_result, [1] overflow
);

  logic [IDX_W-1:0]  front_q, front_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              out_valid_q;
  logic              res_pop_q, res_null_q, res_ovf_q;
  logic [CNT_W-1:0]  res_cnt_q;

  logic              accept;
  cmd_e              cmd;
  logic              is_push, full, empty;
  logic [IDX_W-1:0]  back_free, back_last;
  ring_req_t         req;
  logic [DATA_WIDTH-1:0] rd_data;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign cmd     = cmd_e'(s_axis_tuser_i);
  assign is_push = (cmd == CMD_PUSH_BACK) || (cmd == CMD_PUSH_FRONT);
  assign full    = (count_q == CNT_W'(DEPTH));
  assign empty   = (count_q == '0);

  assign back_free = wrap_add(front_q, count_q[IDX_W-1:0]);
  assign back_last = wrap_add(front_q, IDX_W'(count_q - CNT_W'(1)));

  always_comb begin
    front_d   = front_q;
    count_d   = count_q;
    req.we    = 1'b0;
    req.waddr = back_free;
    req.wdata = s_axis_tdata_i[DATA_WIDTH-1:0];
    req.re    = 1'b0;
    req.raddr = front_q;
    if (accept) begin
      case (cmd)
        CMD_PUSH_BACK: begin
          if (!full) begin
            req.we  = 1'b1;
            count_d = count_q + CNT_W'(1);
          end
        end
        CMD_PUSH_FRONT: begin
          if (!full) begin
            req.we    = 1'b1;
            req.waddr = wrap_dec(front_q);
            front_d   = wrap_dec(front_q);
            count_d   = count_q + CNT_W'(1);
          end
        end
        CMD_POP_BACK: begin
          if (!empty) begin
            req.re    = 1'b1;
            req.raddr = back_last;
            count_d   = count_q - CNT_W'(1);
          end
        end
        CMD_POP_FRONT: begin
          if (!empty) begin
            req.re  = 1'b1;
            front_d = wrap_add(front_q, IDX_W'(1));
            count_d = count_q - CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  deq_ring u_ring (
    .clk_i     (clk_i),
    .req_i     (req),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result flags travel alongside the store read
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_pop_q  <= !is_push && !empty;
      res_null_q <= !is_push && empty;
      res_ovf_q  <= is_push && full;
      res_cnt_q  <= count_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{OUT_PAD_W{1'b0}},
                            COUNT_W'(res_cnt_q),
                            res_pop_q ? OUT_DATA_W'(rd_data) : {OUT_DATA_W{1'b0}}};
  assign m_axis_tuser_o  = {res_ovf_q, res_null_q};

endmodule

`default_nettype wire

FILE: rtl/deq_checker.sv
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks on the queue's result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_checker
  import deq_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tready_o,
  input  wire logic                   m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  input  wire logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input  wire logic [OUT_TUSER_W-1:0] m_axis_tuser_o
);

  logic [COUNT_W-1:0] cnt;
  assign cnt = m_axis_tdata_o[OUT_DATA_W +: COUNT_W];

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result beat changed while stalled");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tuser_o[0] && m_axis_tuser_o[1]))
    else $error("null and overflow both set");

  a_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |->
      cnt == '0 && m_axis_tdata_o[OUT_DATA_W-1:0] == '0)
    else $error("empty pop with nonzero count or data");

  a_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1] |->
      cnt == COUNT_W'(DEPTH) && m_axis_tdata_o[OUT_DATA_W-1:0] == '0)
    else $error("overflow with count not at depth");

  // a result never waits on the input side: input is open whenever output drains
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready_i |-> s_axis_tready_o)
    else $error("input stalled while output drains");

endmodule

bind double_ended_queue_top deq_checker u_deq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire
